/* rtl/core/smt_pkg.sv */
// Shared types, codes and sizing constants for the set membership table.
package smt_pkg;

  localparam int unsigned SMT_CAPACITY = 64;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_QUERY  = 2'd2,
    FN_SPARE  = 2'd3
  } smt_func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } smt_status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } smt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       member;
    logic [6:0] count;
  } smt_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } smt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } smt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
  } smt_stat_t;

endpackage

/* rtl/core/set_membership_table_core.sv */
// Top level of the set membership table: controller plus datapath.
//
//   channel   direction  handshake              payload
//   in_       in         start high, busy low   in_data  (func, value)
//   out_      out        out_strobe, one cycle  out_data (status, member, count)
//
// Busy stays high after an item is taken until its commit: the scan reads one entry
// per cycle through the registered read port, the drain state waits for the last read,
// and the decide state commits; an empty set goes straight to the decide state.
// The result shows in the cycle after the commit, while busy is already low.
// Reset empties the set through the fill count alone; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module set_membership_table_core
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = SMT_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  smt_in_t  in_data,
  output logic     out_strobe,
  output smt_out_t out_data
);

  smt_cmd_t  cmd;
  smt_stat_t stat;

  smt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  smt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

/* rtl/core/smt_ctrl.sv */
// Sequencer for one item: scan the held entries, then decide and commit.
module smt_ctrl
  import smt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  smt_stat_t stat,
  output logic      busy,
  output smt_cmd_t  cmd
);

  smt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = stat.cnt_zero ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN:   cmd.rd_en  = 1'b1;
      S_DRAIN:  ;
      S_DECIDE: cmd.commit = 1'b1;
      default:  ;
    endcase
  end

endmodule

/* rtl/core/smt_datapath.sv */
// Value store, scan comparator, fill count and result register.
module smt_datapath
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = SMT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  smt_in_t   in_data,
  input  smt_cmd_t  cmd,
  output smt_stat_t stat,
  output logic      out_strobe,
  output smt_out_t  out_data
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  // Held values are packed into entries 0 .. count-1
  logic [31:0] mem [CAPACITY];

  logic [1:0]        func_r;
  logic [31:0]       value_r;
  logic [ADDR_W-1:0] addr_r;
  logic [31:0]       rd_data_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              rd_vld_r;
  logic              hit_r;
  logic [ADDR_W-1:0] hit_idx_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_strobe_r;
  smt_out_t          out_data_r, out_data_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic              is_full;

  assign stat.cnt_zero  = (count_r == '0);
  assign stat.scan_last = (CNT_W'(addr_r) == count_r - CNT_W'(1));
  assign is_full        = (count_r >= CNT_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_data.func;
      value_r <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        addr_r <= '0;
        hit_r  <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          addr_r <= addr_r + ADDR_W'(1);
        end
        if (rd_vld_r && rd_data_r == value_r) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && rd_data_r == value_r) begin
      hit_idx_r <= rd_idx_r;
    end
  end

  // Read port: the last read of a scan leaves the top entry in rd_data_r
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr_r];
      rd_idx_r  <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = count_r[ADDR_W-1:0];
    wr_data      = value_r;
    count_nxt    = count_r;
    out_data_nxt = '0;
    priority if (func_r == FN_INSERT) begin
      if (hit_r) begin
        out_data_nxt.status = ST_PRESENT;
        out_data_nxt.member = 1'b1;
      end else if (is_full) begin
        out_data_nxt.status = ST_FULL;
        out_data_nxt.member = 1'b0;
      end else begin
        wr_en               = 1'b1;
        count_nxt           = count_r + CNT_W'(1);
        out_data_nxt.status = ST_DONE;
        out_data_nxt.member = 1'b1;
      end
    end else if (func_r == FN_REMOVE) begin
      out_data_nxt.member = 1'b0;
      if (hit_r) begin
        // move the top entry into the hole
        wr_en               = 1'b1;
        wr_addr             = hit_idx_r;
        wr_data             = rd_data_r;
        count_nxt           = count_r - CNT_W'(1);
        out_data_nxt.status = ST_DONE;
      end else begin
        out_data_nxt.status = ST_ABSENT;
      end
    end else begin
      out_data_nxt.status = hit_r ? ST_DONE : ST_ABSENT;
      out_data_nxt.member = hit_r;
    end
    out_data_nxt.count = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit;
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
